[hw/rtl/pfs_pkg.sv]
// Package for the prime filter sum block: widths, state types and a status struct.
`timescale 1ns / 1ps

package pfs_pkg;

    // Width of the value port and default width of the tested value
    localparam int IN_WIDTH    = 32;
    localparam int VALUE_WIDTH = 32;

    // Width of the running sum and the result
    localparam int SUM_WIDTH   = 48;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_POST
    } pfs_state_t;

    // Primality test sequencer states
    typedef enum logic [1:0] {
        PT_IDLE,
        PT_CHECK,
        PT_DIV
    } pt_state_t;

    // Status of the primality test towards the top level
    typedef struct packed {
        logic done;
        logic prime;
    } test_status_t;

endpackage

[hw/rtl/pfs_rem_unit.sv]
// Bit-serial restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module pfs_rem_unit #(
    parameter int VALUE_WIDTH = pfs_pkg::VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;

    // Shift in the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            // Keep the difference unless it went negative
            if (!trial[VALUE_WIDTH]) begin
                rem_next = trial[VALUE_WIDTH-1:0];
            end else begin
                rem_next = shifted[VALUE_WIDTH-1:0];
            end
            quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/pfs_prime_test.sv]
// Trial-division sequencer: walks odd divisors and drives its own remainder unit.
`timescale 1ns / 1ps

module pfs_prime_test #(
    parameter int VALUE_WIDTH = pfs_pkg::VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    output pfs_pkg::test_status_t  status
);

    pfs_pkg::pt_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH:0]   sq_reg, sq_next;
    logic                   done_reg, done_next;
    logic                   prime_reg, prime_next;

    logic                   rem_start;
    logic                   rem_done;
    logic [VALUE_WIDTH-1:0] rem_value;
    logic [VALUE_WIDTH+2:0] sq_sum;
    logic                   value_small;

    // (d+2)^2 = d^2 + 4d + 4
    assign sq_sum = {2'b00, sq_reg} + {1'b0, d_reg, 2'b00} + (VALUE_WIDTH+3)'(4);

    // Negative, zero or one
    assign value_small = value[VALUE_WIDTH-1] || (value <= VALUE_WIDTH'(1));

    always_comb begin
        state_next = state_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        rem_start  = 1'b0;
        case (state_reg)
            pfs_pkg::PT_IDLE: begin
                if (start) begin
                    v_next = value;
                    if (value_small) begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end else if (!value[0]) begin
                        // Even: prime only for two
                        done_next  = 1'b1;
                        prime_next = (value == VALUE_WIDTH'(2));
                    end else begin
                        d_next     = VALUE_WIDTH'(3);
                        sq_next    = (VALUE_WIDTH+1)'(9);
                        state_next = pfs_pkg::PT_CHECK;
                    end
                end
            end
            pfs_pkg::PT_CHECK: begin
                // Stop once the divisor squared passes the value
                if (sq_reg > {1'b0, v_reg}) begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = pfs_pkg::PT_IDLE;
                end else begin
                    rem_start  = 1'b1;
                    state_next = pfs_pkg::PT_DIV;
                end
            end
            pfs_pkg::PT_DIV: begin
                if (rem_done) begin
                    if (rem_value == '0) begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = pfs_pkg::PT_IDLE;
                    end else begin
                        d_next     = d_reg + VALUE_WIDTH'(2);
                        sq_next    = sq_sum[VALUE_WIDTH:0];
                        state_next = pfs_pkg::PT_CHECK;
                    end
                end
            end
            default: begin
                state_next = pfs_pkg::PT_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfs_pkg::PT_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg     <= v_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        prime_reg <= prime_next;
    end

    pfs_rem_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .done     (rem_done),
        .remainder(rem_value)
    );

    assign status.done  = done_reg;
    assign status.prime = prime_reg;

endmodule

[hw/rtl/prime_filter_sum.sv]
// Top level of the prime filter sum block: input sequencer, running sum, result register.
`timescale 1ns / 1ps

// Usage
// - Input channel s_valid/s_ready carries s_value (signed) and s_last. Only the
//   low VALUE_WIDTH bits of s_value are used, read as a signed number.
// - Each prime value is added into a 48-bit running sum that saturates at its
//   maximum. An item with s_last high puts the sum, that item included, on the
//   result channel m_valid/m_ready as m_prime_sum and clears the sum.
// - s_ready is high only while no item is in work; one item is tested at a time
//   by trial division through one bit-serial remainder unit.
// - Negative, zero, one and even values are decided without division; for an odd
//   value v, odd divisors from 3 upward are tried up to sqrt(v) on the remainder
//   unit, which takes one dividend bit per cycle.
// - After the test of a last item reports done, the block moves to ST_POST and,
//   once the output is free, raises m_valid; the result sits in an output
//   register and the next item is taken while it waits.
// - If the receiver stalls, a further last item holds in the block until the
//   waiting result is taken; s_ready stays low meanwhile.
// - Reset clears the running sum, the sequencers and m_valid.
module prime_filter_sum #(
    parameter int VALUE_WIDTH = pfs_pkg::VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pfs_pkg::IN_WIDTH-1:0]  s_value,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pfs_pkg::SUM_WIDTH-1:0] m_prime_sum
);

    localparam int SW = pfs_pkg::SUM_WIDTH;

    pfs_pkg::pfs_state_t   state_reg, state_next;
    pfs_pkg::test_status_t test_status;

    logic [VALUE_WIDTH-1:0] raw_reg, raw_next;
    logic                   last_reg, last_next;
    logic                   prime_reg, prime_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SW-1:0]          m_sum_reg, m_sum_next;

    logic                   s_accept;
    logic                   out_free;
    logic [SW:0]            add_sum;
    logic [SW-1:0]          sat_sum;
    logic [SW-1:0]          addend;

    assign s_ready  = (state_reg == pfs_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Saturating add of a prime value
    assign addend  = prime_reg ? {{(SW - VALUE_WIDTH){1'b0}}, raw_reg} : '0;
    assign add_sum = {1'b0, sum_reg} + {1'b0, addend};
    assign sat_sum = add_sum[SW] ? {SW{1'b1}} : add_sum[SW-1:0];

    always_comb begin
        state_next   = state_reg;
        raw_next     = raw_reg;
        last_next    = last_reg;
        prime_next   = prime_reg;
        sum_next     = sum_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next   = m_sum_reg;
        case (state_reg)
            pfs_pkg::ST_IDLE: begin
                if (s_accept) begin
                    raw_next   = s_value[VALUE_WIDTH-1:0];
                    last_next  = s_last;
                    state_next = pfs_pkg::ST_TEST;
                end
            end
            pfs_pkg::ST_TEST: begin
                if (test_status.done) begin
                    prime_next = test_status.prime;
                    state_next = pfs_pkg::ST_POST;
                end
            end
            pfs_pkg::ST_POST: begin
                // Add, then emit and clear on the last item once the output is free
                if (!last_reg) begin
                    sum_next   = sat_sum;
                    state_next = pfs_pkg::ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = sat_sum;
                    sum_next     = '0;
                    state_next   = pfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfs_pkg::ST_IDLE;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg   <= raw_next;
        last_reg  <= last_next;
        prime_reg <= prime_next;
        m_sum_reg <= m_sum_next;
    end

    pfs_prime_test #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_test (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (s_accept),
        .value  (s_value[VALUE_WIDTH-1:0]),
        .status (test_status)
    );

    assign m_valid     = m_valid_reg;
    assign m_prime_sum = m_sum_reg;

    // A result only rises after a last item is posted
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == pfs_pkg::ST_POST && last_reg))
        else $error("result raised without a last item");

    // The test only finishes while an item is in test
    a_done_in_test: assert property (@(posedge aclk) disable iff (!aresetn)
        test_status.done |-> (state_reg == pfs_pkg::ST_TEST))
        else $error("prime test finished outside of test state");

    // Emitting a result clears the running sum
    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfs_pkg::ST_POST && last_reg && out_free) |=> (sum_reg == '0))
        else $error("running sum not cleared after result");

    // A waiting result holds while the receiver stalls
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_prime_sum)))
        else $error("stalled result changed");

endmodule
